FILE: hw/rtl/tsc_pkg.sv
// Shared types and constants for the Taylor sine/cosine core.
package tsc_pkg;

   localparam int MAX_TERMS_DEF  = 16;
   localparam int GUARD_BITS_DEF = 10;

   // pi scaled by 2^62, rounded to nearest
   localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

   // conditional subtract steps for the 2*pi remainder (quotient below 64)
   localparam int RED_STEPS = 6;

   localparam int THR_W       = 30;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam logic [THR_W-1:0] THR_RESET = 30'd1;

   // register index codes
   localparam logic [CSR_AW-3:0] REG_THRESHOLD = 1'b0;

   typedef struct packed {
      logic valid;
      logic neg;    // result sign to apply
      logic run;    // series still summing
      logic red;    // angle needs 2*pi reduction
   } tsc_ctl_type;

endpackage

FILE: hw/rtl/tsc_mul.sv
// Two-stage unsigned multiplier built from 32x32 partial products.
module tsc_mul
   import tsc_pkg::*;
#(
   parameter int AW = 32,
   parameter int BW = 32
)(
   input  logic              clock,
   input  logic              en,
   input  logic [AW-1:0]     a,
   input  logic [BW-1:0]     b,
   output logic [AW+BW-1:0]  p
);

   localparam int MAXW = (AW > BW) ? AW : BW;
   localparam int NL   = (MAXW + 31) / 32;
   localparam int PW   = NL * 64;

   logic [NL*32-1:0] a_ext;
   logic [NL*32-1:0] b_ext;
   logic [63:0]      pp_ff [NL*NL];
   logic [PW-1:0]    acc;
   logic [AW+BW-1:0] p_ff;

   assign a_ext = (NL*32)'(a);
   assign b_ext = (NL*32)'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               pp_ff[i*NL+j] <= a_ext[i*32 +: 32] * b_ext[j*32 +: 32];
            end
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NL; i++) begin
         for (int j = 0; j < NL; j++) begin
            acc = acc + (PW'(pp_ff[i*NL+j]) << (32*(i+j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= acc[AW+BW-1:0];
      end
   end

   assign p = p_ff;

endmodule

FILE: hw/rtl/tsc_term.sv
// One series term: quotient x^2/d by reciprocal, times previous term, accumulate.
module tsc_term
   import tsc_pkg::*;
#(
   parameter int FB  = 40,
   parameter int XW  = 46,
   parameter int EW  = 47,
   parameter int SW  = 49,
   parameter int IDX = 1
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [FB-1:0]         thr,
   input  tsc_ctl_type           ctl_in,
   input  logic [EW-1:0]         elem_in,
   input  logic [XW-1:0]         x2_in,
   input  logic signed [SW-1:0]  sum_in,
   output tsc_ctl_type           ctl_out,
   output logic [EW-1:0]         elem_out,
   output logic [XW-1:0]         x2_out,
   output logic signed [SW-1:0]  sum_out
);

   localparam int D   = (2*IDX) * (2*IDX + 1);
   localparam int S   = XW + 12;
   localparam int RW  = S - 2;
   localparam int QW  = XW - 2;
   localparam logic [127:0] RECIP = ((128'd1 << S) + D - 1) / D;
   localparam bit   SUB = (IDX % 2) == 1;

   tsc_ctl_type           ctl_d_ff  [4];
   logic [EW-1:0]         elem_d_ff [4];
   logic [XW-1:0]         x2_d_ff   [4];
   logic signed [SW-1:0]  sum_d_ff  [4];

   tsc_ctl_type           ctl_o_ff;
   logic [EW-1:0]         elem_o_ff;
   logic [XW-1:0]         x2_o_ff;
   logic signed [SW-1:0]  sum_o_ff;

   tsc_ctl_type           ctl_in0;
   logic [XW+RW-1:0]      pa;
   logic [QW-1:0]         q;
   logic [EW+QW-1:0]      pb;
   logic [EW-1:0]         term_new;
   logic signed [SW-1:0]  term_s;
   logic [EW-1:0]         elem_o_in;
   logic signed [SW-1:0]  sum_o_in;

   always_comb begin
      ctl_in0     = ctl_in;
      ctl_in0.run = ctl_in.run && (elem_in > EW'(thr));
   end

   tsc_mul #(.AW(XW), .BW(RW)) u_recip (
      .clock (clock),
      .en    (en),
      .a     (x2_in),
      .b     (RW'(RECIP)),
      .p     (pa)
   );

   assign q = pa[S +: QW];

   tsc_mul #(.AW(EW), .BW(QW)) u_prod (
      .clock (clock),
      .en    (en),
      .a     (elem_d_ff[1]),
      .b     (q),
      .p     (pb)
   );

   assign term_new = pb[FB +: EW];
   assign term_s   = $signed({{(SW-EW){1'b0}}, term_new});

   always_comb begin
      elem_o_in = elem_d_ff[3];
      sum_o_in  = sum_d_ff[3];
      if (ctl_d_ff[3].run) begin
         elem_o_in = term_new;
         sum_o_in  = SUB ? (sum_d_ff[3] - term_s) : (sum_d_ff[3] + term_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            ctl_d_ff[i] <= '0;
         end
         ctl_o_ff <= '0;
      end else if (en) begin
         ctl_d_ff[0] <= ctl_in0;
         for (int i = 1; i < 4; i++) begin
            ctl_d_ff[i] <= ctl_d_ff[i-1];
         end
         ctl_o_ff <= ctl_d_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         elem_d_ff[0] <= elem_in;
         x2_d_ff[0]   <= x2_in;
         sum_d_ff[0]  <= sum_in;
         for (int i = 1; i < 4; i++) begin
            elem_d_ff[i] <= elem_d_ff[i-1];
            x2_d_ff[i]   <= x2_d_ff[i-1];
            sum_d_ff[i]  <= sum_d_ff[i-1];
         end
         elem_o_ff <= elem_o_in;
         x2_o_ff   <= x2_d_ff[3];
         sum_o_ff  <= sum_o_in;
      end
   end

   assign ctl_out  = ctl_o_ff;
   assign elem_out = elem_o_ff;
   assign x2_out   = x2_o_ff;
   assign sum_out  = sum_o_ff;

endmodule

FILE: hw/rtl/taylor_sine_cosine_core.sv
// Taylor sine/cosine core: top level with angle reduction, term chain and output stage.
//
// Fully pipelined: one angle is accepted per cycle while req_tready is high.
// In the term chain every series term owns a five-stage unit (reciprocal
// multiply for x^2/d, then product with the previous term). Terms past the
// stop point flow through unchanged. Results leave through an output register
// backed by one skid entry; while the skid entry is occupied the whole
// pipeline holds and req_tready is low.
module taylor_sine_cosine_core
   import tsc_pkg::*;
#(
   parameter int MAX_TERMS  = MAX_TERMS_DEF,
   parameter int GUARD_BITS = GUARD_BITS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   // angle input
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] angle, Q8.24 signed
   input  logic [0:0]        req_tuser,   // [0] mode: 0 sine, 1 cosine
   // result output
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata    // [31:0] value, Q2.30 signed
);

   localparam int FB   = 30 + GUARD_BITS;
   localparam int XSW  = FB + 9;
   localparam int MW0  = FB + 8;
   localparam int MW   = FB + 3;
   localparam int XW   = FB + 6;
   localparam int EW   = FB + 7;
   localparam int SW   = FB + 9;
   localparam int NT   = MAX_TERMS - 1;
   localparam int RNW  = SW - GUARD_BITS;

   localparam logic [63:0] HALF_PI_F = (PI_Q62 + (64'd1 << (62 - FB))) >> (63 - FB);
   localparam logic [63:0] TWO_PI_F  = (PI_Q62 + (64'd1 << (60 - FB))) >> (61 - FB);
   localparam logic [63:0] ROUND_HALF =
      (GUARD_BITS > 0) ? (64'd1 << (GUARD_BITS - 1)) : 64'd0;

   // ---------------- configuration ----------------
   logic [THR_W-1:0] thr_ff, thr_in;
   logic             csr_wr;
   logic             sel_thr;
   logic [FB-1:0]    thr_f;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign sel_thr    = (csr_paddr[CSR_AW-1:2] == REG_THRESHOLD);
   assign thr_in     = (csr_wr && sel_thr) ? csr_pwdata[THR_W-1:0] : thr_ff;
   assign csr_prdata = sel_thr ? CSR_DW'(thr_ff) : '0;
   assign thr_f      = FB'(thr_ff) << GUARD_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // ---------------- flow control ----------------
   logic en;
   logic skid_valid_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // ---------------- stage A: scale, cosine shift ----------------
   tsc_ctl_type            sa_ctl_ff, sa_ctl_in;
   logic signed [XSW-1:0]  sa_x_ff, sa_x_in, ang_x;

   assign ang_x = XSW'($signed(req_tdata)) <<< (FB - 24);

   always_comb begin
      sa_ctl_in       = '0;
      sa_ctl_in.valid = req_tvalid;
      sa_x_in         = req_tuser[0] ? ($signed(XSW'(HALF_PI_F)) - ang_x) : ang_x;
   end

   // ---------------- stage B: magnitude ----------------
   tsc_ctl_type      sb_ctl_ff, sb_ctl_in;
   logic [MW0-1:0]   sb_m_ff, sb_m_in;

   always_comb begin
      sb_ctl_in     = sa_ctl_ff;
      sb_ctl_in.neg = sa_x_ff[XSW-1];
      sb_m_in       = sa_x_ff[XSW-1] ? MW0'(-sa_x_ff) : MW0'(sa_x_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ctl_ff <= '0;
         sb_ctl_ff <= '0;
      end else if (en) begin
         sa_ctl_ff <= sa_ctl_in;
         sb_ctl_ff <= sb_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_x_ff <= sa_x_in;
         sb_m_ff <= sb_m_in;
      end
   end

   // ---------------- 2*pi remainder, one subtract per stage ----------------
   logic [MW0-1:0] rd_m [RED_STEPS+1];
   tsc_ctl_type    rd_c [RED_STEPS+1];

   assign rd_m[0] = sb_m_ff;
   assign rd_c[0] = sb_ctl_ff;

   for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
      localparam logic [MW0-1:0] STEP = MW0'(TWO_PI_F) << (RED_STEPS - 1 - k);
      tsc_ctl_type    ctl_ff, ctl_in;
      logic [MW0-1:0] m_ff, m_in;
      logic           red;

      // exactly 2*pi is kept as is
      assign red = (k == 0) ? (rd_m[0] > MW0'(TWO_PI_F)) : rd_c[k].red;

      always_comb begin
         ctl_in     = rd_c[k];
         ctl_in.red = red;
         m_in       = (red && (rd_m[k] >= STEP)) ? (rd_m[k] - STEP) : rd_m[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff <= '0;
         end else if (en) begin
            ctl_ff <= ctl_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff <= m_in;
         end
      end

      assign rd_m[k+1] = m_ff;
      assign rd_c[k+1] = ctl_ff;
   end

   // ---------------- x^2 ----------------
   logic [MW-1:0]   m_red;
   logic [2*MW-1:0] sq_p;
   tsc_ctl_type     sq_ctl_ff [2];
   logic [MW-1:0]   sq_m_ff   [2];

   assign m_red = MW'(rd_m[RED_STEPS]);

   tsc_mul #(.AW(MW), .BW(MW)) u_square (
      .clock (clock),
      .en    (en),
      .a     (m_red),
      .b     (m_red),
      .p     (sq_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl_ff[0] <= '0;
         sq_ctl_ff[1] <= '0;
      end else if (en) begin
         sq_ctl_ff[0] <= rd_c[RED_STEPS];
         sq_ctl_ff[1] <= sq_ctl_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_m_ff[0] <= m_red;
         sq_m_ff[1] <= sq_m_ff[0];
      end
   end

   // ---------------- term chain ----------------
   tsc_ctl_type           tm_ctl  [NT+1];
   logic [EW-1:0]         tm_elem [NT+1];
   logic [XW-1:0]         tm_x2   [NT+1];
   logic signed [SW-1:0]  tm_sum  [NT+1];

   always_comb begin
      tm_ctl[0]     = sq_ctl_ff[1];
      tm_ctl[0].run = 1'b1;
   end
   assign tm_elem[0] = EW'(sq_m_ff[1]);
   assign tm_x2[0]   = sq_p[FB +: XW];
   assign tm_sum[0]  = $signed(SW'(sq_m_ff[1]));

   for (genvar t = 1; t <= NT; t++) begin : g_term
      tsc_term #(
         .FB  (FB),
         .XW  (XW),
         .EW  (EW),
         .SW  (SW),
         .IDX (t)
      ) u_term (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .thr      (thr_f),
         .ctl_in   (tm_ctl[t-1]),
         .elem_in  (tm_elem[t-1]),
         .x2_in    (tm_x2[t-1]),
         .sum_in   (tm_sum[t-1]),
         .ctl_out  (tm_ctl[t]),
         .elem_out (tm_elem[t]),
         .x2_out   (tm_x2[t]),
         .sum_out  (tm_sum[t])
      );
   end

   // ---------------- sign, round, saturate ----------------
   tsc_ctl_type      f1_ctl_ff, f1_ctl_in;
   logic [SW-2:0]    f1_mag_ff, f1_mag_in;
   tsc_ctl_type      f2_ctl_ff;
   logic [RNW-1:0]   f2_r_ff, f2_r_in;
   logic [SW-1:0]    rnd_sum;
   tsc_ctl_type      f3_ctl_ff;
   logic [31:0]      f3_val_ff, f3_val_in;
   logic signed [SW-1:0] fsum;

   assign fsum = tm_sum[NT];

   always_comb begin
      f1_ctl_in     = tm_ctl[NT];
      // sign after negation; a zero sum stays non-negative
      f1_ctl_in.neg = (fsum != '0) && (tm_ctl[NT].neg ^ fsum[SW-1]);
      f1_mag_in     = fsum[SW-1] ? (SW-1)'(-fsum) : (SW-1)'(fsum);
   end

   assign rnd_sum = SW'(f1_mag_ff) + SW'(ROUND_HALF);
   assign f2_r_in = rnd_sum[GUARD_BITS +: RNW];

   always_comb begin
      if (f2_ctl_ff.neg) begin
         f3_val_in = (f2_r_ff > RNW'(64'h8000_0000)) ? 32'h8000_0000
                                                    : (32'd0 - f2_r_ff[31:0]);
      end else begin
         f3_val_in = (f2_r_ff > RNW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : f2_r_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ctl_ff <= '0;
         f2_ctl_ff <= '0;
         f3_ctl_ff <= '0;
      end else if (en) begin
         f1_ctl_ff <= f1_ctl_in;
         f2_ctl_ff <= f1_ctl_ff;
         f3_ctl_ff <= f2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_mag_ff <= f1_mag_in;
         f2_r_ff   <= f2_r_in;
         f3_val_ff <= f3_val_in;
      end
   end

   // ---------------- output register and skid entry ----------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        skid_valid_in;
   logic [31:0] skid_data_ff, skid_data_in;
   logic        take;

   assign take = rsp_valid_ff && rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (f3_ctl_ff.valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = f3_val_ff;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = f3_val_ff;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry occupied while output register empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("skid entry dropped without a transfer");

   a_tail_held: assert property (@(posedge clock) disable iff (reset)
      !en && f3_ctl_ff.valid |=> f3_ctl_ff.valid && $stable(f3_val_ff))
      else $error("pipeline tail moved during stall");

   a_tail_to_out: assert property (@(posedge clock) disable iff (reset)
      en && f3_ctl_ff.valid && !rsp_valid_ff |=>
         rsp_valid_ff && (rsp_data_ff == $past(f3_val_ff)))
      else $error("result did not reach output register");

endmodule

FILE: tb/tb_top.sv
// Testbench for the Taylor sine/cosine core: scoreboard, stimulus, register writes, checks.
`timescale 1ns / 1ps

module tb_top;
   import tsc_pkg::*;

   localparam int          N_TERMS  = 16;
   localparam int          GUARD    = 10;
   localparam int          FRAC     = 30 + GUARD;
   localparam logic [63:0] HALF_PI  = (PI_Q62 + (64'd1 << (62 - FRAC))) >> (63 - FRAC);
   localparam logic [63:0] TWO_PI   = (PI_Q62 + (64'd1 << (60 - FRAC))) >> (61 - FRAC);
   localparam int          SETTLE   = 120;
   localparam int          LIMIT    = 600000;
   // 2*pi in Q8.24
   localparam int          TWO_PI_Q24 = 105414357;

   class sincos_scoreboard;
      logic [29:0] threshold;
      logic [31:0] value_q[$];
      int          errors;
      int          checked;

      function new();
         threshold = THR_RESET;
         errors    = 0;
         checked   = 0;
      endfunction

      function void write_reg(logic [CSR_AW-1:0] addr, logic [31:0] data);
         if (addr[CSR_AW-1:2] == REG_THRESHOLD)
            threshold = data[29:0];
      endfunction

      function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         p = p >> FRAC;
         return p[63:0];
      endfunction

      function logic [31:0] sin_cos(logic mode, logic signed [31:0] angle);
         longint      x;
         longint      sum;
         logic [63:0] m, x2, elem, thr, mag, r, d;
         logic        neg;
         int          i, count;
         x = longint'(angle) * (64'sd1 <<< (FRAC - 24));
         if (mode)
            x = longint'(HALF_PI) - x;
         neg = x < 0;
         m = neg ? -x : x;
         if (m > TWO_PI)
            m = m % TWO_PI;
         x2 = mul_shift(m, m);
         thr = {34'd0, threshold} << GUARD;
         elem = m;
         sum = m;
         count = 1;
         for (i = 1; elem > thr && count < N_TERMS; i++, count++) begin
            d = 64'((2 * i) * (2 * i + 1));
            elem = mul_shift(elem, x2 / d);
            if (i & 1)
               sum = sum - longint'(elem);
            else
               sum = sum + longint'(elem);
         end
         if (neg)
            sum = -sum;
         mag = sum < 0 ? -sum : sum;
         r = (mag + (64'd1 << (GUARD - 1))) >> GUARD;
         if (sum < 0)
            return r > 64'h8000_0000 ? 32'h8000_0000 : 32'(-r);
         else
            return r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
      endfunction

      function void note_angle(logic mode, logic [31:0] angle);
         value_q.push_back(sin_cos(mode, angle));
      endfunction

      function void check_value(logic [31:0] actual);
         logic [31:0] want;
         checked++;
         if (value_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, actual);
            errors++;
            return;
         end
         want = value_q.pop_front();
         if (actual !== want) begin
            $display("%0t: value mismatch, expected %h, actual %h", $time, want, actual);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   logic              req_tvalid, req_tready;
   logic [31:0]       req_tdata;   // [31:0] angle
   logic [0:0]        req_tuser;   // [0] mode
   logic              rsp_tvalid, rsp_tready;
   logic [31:0]       rsp_tdata;   // [31:0] value

   sincos_scoreboard sb;
   int               cycles;
   int               sent;
   bit               quiet;

   taylor_sine_cosine_core i_dut (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      sb = new();
      cycles = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout at %0t", $time);
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_value(rsp_tdata);

   // receiver stalls in random bursts
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         n = $urandom_range(1, 20);
         repeat (n) @(posedge clock);
      end
   end

   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_reg(addr, data);
   endtask

   task automatic send_angle(logic mode, logic [31:0] angle);
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      sb.note_angle(mode, angle);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.value_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_angle();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom();
         3:       return TWO_PI_Q24 + $urandom_range(0, 4) - 2;
         4:       return -TWO_PI_Q24 + $urandom_range(0, 4) - 2;
         5:       return $urandom_range(0, 2048) - 1024;
         default: return $urandom_range(0, 4 * TWO_PI_Q24) - 2 * TWO_PI_Q24;
      endcase
   endfunction

   initial begin
      logic [29:0] thr_list[6];
      int k, j;
      thr_list = '{30'd0, 30'h3FFF_FFFF, 30'd1 << 12, 30'd7, 30'd1 << 20, 30'd1};
      sent = 0;
      quiet = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, both modes, 2*pi boundary, reset threshold
      for (k = 0; k < 2; k++) begin
         send_angle(1'(k), 32'h0000_0000);
         send_angle(1'(k), 32'h7FFF_FFFF);
         send_angle(1'(k), 32'h8000_0000);
         send_angle(1'(k), TWO_PI_Q24);
         send_angle(1'(k), -TWO_PI_Q24);
         send_angle(1'(k), TWO_PI_Q24 + 1);
         send_angle(1'(k), 32'd26353589);   // about pi/2
         send_angle(1'(k), 32'hFFFF_FFFF);
         send_angle(1'(k), 32'd52707179);   // about pi
         send_angle(1'(k), 32'h0000_0001);
      end
      drain();

      // a write to an unused index must leave the threshold alone
      csr_write(3'd4, 32'h0000_0000);
      for (k = 0; k < 5; k++)
         send_angle(1'($urandom_range(0, 1)), pick_angle());
      drain();

      for (j = 0; j < 6; j++) begin
         csr_write(3'd0, {2'($urandom_range(0, 3)), thr_list[j]});
         if (j == 5)
            quiet = 1'b1;
         for (k = 0; k < 170; k++)
            send_angle(1'($urandom_range(0, 1)), pick_angle());
         drain();
      end

      $display("sent %0d angles over 6 threshold settings, checked %0d results",
               sent, sb.checked);
      if (sb.errors == 0 && sb.value_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
